>>> design/pfo_pkg.sv
// Shared types, constants and helpers for the flux observer with angle tracking loop.
package pfo_pkg;

	localparam int CORDIC_STEPS = 16;
	localparam int ATAN_ENTRIES = 24;
	localparam int CW = 40;
	localparam int ADDR_W = 5;

	localparam logic [31:0] ATAN_TURNS [ATAN_ENTRIES] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
		32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
		32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
		32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
	};

	localparam logic [31:0] QUARTER_TURN = 32'h40000000;
	localparam logic [31:0] THREE_QUARTER_TURN = 32'hC0000000;

	typedef enum logic [2:0] {
		REG_RESISTANCE    = 3'd0,
		REG_INDUCTANCE    = 3'd1,
		REG_FLUX_LINKAGE  = 3'd2,
		REG_GAMMA_HALF_DT = 3'd3,
		REG_STEP_SECONDS  = 3'd4,
		REG_PLL_PROP      = 3'd5,
		REG_PLL_INTEGRAL  = 3'd6,
		REG_NONE          = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic [15:0] resistance;
		logic [23:0] inductance;
		logic [23:0] flux_linkage;
		logic [23:0] gamma_half_dt;
		logic [23:0] step_seconds;
		logic [15:0] pll_prop_gain;
		logic [23:0] pll_integral_gain;
	} cfg_t;

	typedef struct packed {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic [31:0] ang;
	} cord_t;

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		if (v > 64'sd2147483647)
			return 32'sh7FFFFFFF;
		else if (v < -64'sd2147483648)
			return 32'sh80000000;
		else
			return v[31:0];
	endfunction

endpackage

>>> design/pfo_cfg_regs.sv
// Register file behind the configuration port.
module pfo_cfg_regs import pfo_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	output cfg_t              cfg
);
	cfg_t     cfg_q;
	reg_idx_t idx;

	assign idx = reg_idx_t'(paddr[4:2]);
	assign pready = 1'b1;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.resistance        <= 16'd1229;
			cfg_q.inductance        <= 24'd14156;
			cfg_q.flux_linkage      <= 24'd405272;
			cfg_q.gamma_half_dt     <= 24'd2070528;
			cfg_q.step_seconds      <= 24'd214748;
			cfg_q.pll_prop_gain     <= 16'd9830;
			cfg_q.pll_integral_gain <= 24'd429497;
		end else if (psel && penable && pwrite && pready) begin
			unique case (idx)
				REG_RESISTANCE:    cfg_q.resistance        <= pwdata[15:0];
				REG_INDUCTANCE:    cfg_q.inductance        <= pwdata[23:0];
				REG_FLUX_LINKAGE:  cfg_q.flux_linkage      <= pwdata[23:0];
				REG_GAMMA_HALF_DT: cfg_q.gamma_half_dt     <= pwdata[23:0];
				REG_STEP_SECONDS:  cfg_q.step_seconds      <= pwdata[23:0];
				REG_PLL_PROP:      cfg_q.pll_prop_gain     <= pwdata[15:0];
				REG_PLL_INTEGRAL:  cfg_q.pll_integral_gain <= pwdata[23:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_RESISTANCE:    prdata = {16'd0, cfg_q.resistance};
			REG_INDUCTANCE:    prdata = {8'd0, cfg_q.inductance};
			REG_FLUX_LINKAGE:  prdata = {8'd0, cfg_q.flux_linkage};
			REG_GAMMA_HALF_DT: prdata = {8'd0, cfg_q.gamma_half_dt};
			REG_STEP_SECONDS:  prdata = {8'd0, cfg_q.step_seconds};
			REG_PLL_PROP:      prdata = {16'd0, cfg_q.pll_prop_gain};
			REG_PLL_INTEGRAL:  prdata = {8'd0, cfg_q.pll_integral_gain};
			default:           prdata = 32'd0;
		endcase
	end

endmodule

>>> design/pfo_cordic_cell.sv
// One vectoring CORDIC micro-rotation with its output register.
module pfo_cordic_cell import pfo_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [4:0]  shift,
	input  logic [31:0] atan_step,
	input  logic        in_valid,
	input  cord_t       in_word,
	output logic        out_valid,
	output cord_t       out_word
);
	logic          valid_q;
	cord_t         word_q;
	logic signed [CW-1:0] dx, dy;
	cord_t         nxt;

	assign dx = in_word.y >>> shift;
	assign dy = in_word.x >>> shift;

	always_comb begin
		if (in_word.y > 0) begin
			nxt.x   = in_word.x + dx;
			nxt.y   = in_word.y - dy;
			nxt.ang = in_word.ang + atan_step;
		end else begin
			nxt.x   = in_word.x - dx;
			nxt.y   = in_word.y + dy;
			nxt.ang = in_word.ang - atan_step;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else
			valid_q <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (in_valid)
			word_q <= nxt;
	end

	assign out_valid = valid_q;
	assign out_word = word_q;

endmodule

>>> design/pmsm_flux_observer_pll.sv
// Top level: flux observer sequencer, CORDIC cell row and tracking loop.
//
//  channel | dir | handshake                  | payload
//  s_*     | in  | s_tvalid/s_tready          | currents and voltages, one word per period
//  m_*     | out | m_tvalid/m_tready          | observer angle, tracked angle, speed
//  apb     | in  | psel/penable/pwrite/pready | seven gain and motor registers
//
// A word passes the states LI, E, SQ, ERR, G, C, F and ROT, then the row of CORDIC_STEPS
// cells, one cell per cycle, then PLL1 and PLL2 on its way from acceptance to result.
// A new word can be taken the cycle after the result is loaded, never while one is in flight.
// The last step waits while an earlier result is still not taken.
// Reset clears the flux states, the loop phase and rate, and loads register defaults.
module pmsm_flux_observer_pll import pfo_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [63:0]       s_tdata,  // current_alpha, current_beta, voltage_alpha, voltage_beta
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [63:0]       m_tdata,  // observed_angle, tracked_angle, tracked_speed
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);
	typedef enum logic [11:0] {
		ST_IDLE = 12'b000000000001,
		ST_LI   = 12'b000000000010,
		ST_E    = 12'b000000000100,
		ST_SQ   = 12'b000000001000,
		ST_ERR  = 12'b000000010000,
		ST_G    = 12'b000000100000,
		ST_C    = 12'b000001000000,
		ST_F    = 12'b000010000000,
		ST_ROT  = 12'b000100000000,
		ST_COR  = 12'b001000000000,
		ST_PLL1 = 12'b010000000000,
		ST_PLL2 = 12'b100000000000
	} state_t;

	state_t state_q;
	cfg_t   cfg;

	logic signed [15:0] ia_q, ib_q, va_q, vb_q;
	logic signed [31:0] flux_a_q, flux_b_q;
	logic [31:0]        phase_q;
	logic signed [31:0] rate_q;

	logic signed [36:0] li_a_q, li_b_q;
	logic signed [32:0] ri_a_q, ri_b_q;
	logic [47:0]        psi2_q;
	logic signed [25:0] sa_q, sb_q;
	logic signed [21:0] e20_a_q, e20_b_q;
	logic signed [33:0] drv22_a_q, drv22_b_q;
	logic signed [51:0] sqa_q, sqb_q;
	logic signed [58:0] drv_a_q, drv_b_q;
	logic signed [37:0] err32_q;
	logic signed [34:0] dr30_a_q, dr30_b_q;
	logic signed [38:0] g20_q;
	logic signed [50:0] corr_a_q, corr_b_q;
	logic signed [37:0] x0_q, y0_q;
	logic               zero_q;
	logic [31:0]        seen_q;
	logic signed [32:0] pg_q;
	logic signed [24:0] ig_q;
	logic               m_valid_q;
	logic [63:0]        m_data_q;

	// flux path and tracking loop combinational terms
	logic signed [40:0] la_prod, lb_prod;
	logic signed [37:0] ea, eb;
	logic signed [31:0] sat_ea, sat_eb;
	logic signed [53:0] err_full;
	logic signed [62:0] g_prod;
	logic signed [60:0] ca_prod, cb_prod;
	logic signed [51:0] fa_sum, fb_sum;
	logic signed [31:0] na, nb;
	logic signed [31:0] d;
	logic signed [48:0] kp_prod;
	logic signed [56:0] ki_prod;
	logic [31:0]        new_phase;
	logic signed [31:0] new_rate;
	logic               pll_go;

	cord_t              rot_word;
	cord_t              chain_w [CORDIC_STEPS+1];
	logic [CORDIC_STEPS:0] cv;

	pfo_cfg_regs u_cfg (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .cfg(cfg)
	);

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;
	assign pll_go   = !m_valid_q || m_tready;

	assign la_prod = $signed({1'b0, cfg.inductance}) * ia_q;
	assign lb_prod = $signed({1'b0, cfg.inductance}) * ib_q;
	assign ea = {{6{flux_a_q[31]}}, flux_a_q} - {li_a_q[36], li_a_q};
	assign eb = {{6{flux_b_q[31]}}, flux_b_q} - {li_b_q[36], li_b_q};
	assign sat_ea = sat32(64'(ea));
	assign sat_eb = sat32(64'(eb));
	assign err_full = $signed({6'd0, psi2_q}) - (54'(sqa_q) + 54'(sqb_q));
	assign g_prod = $signed({1'b0, cfg.gamma_half_dt}) * err32_q;
	assign ca_prod = g20_q * e20_a_q;
	assign cb_prod = g20_q * e20_b_q;
	assign fa_sum = 52'(flux_a_q) + 52'(dr30_a_q) + 52'(corr_a_q);
	assign fb_sum = 52'(flux_b_q) + 52'(dr30_b_q) + 52'(corr_b_q);
	assign na = sat32(64'(fa_sum));
	assign nb = sat32(64'(fb_sum));

	assign d = $signed(seen_q - phase_q);
	assign kp_prod = $signed({1'b0, cfg.pll_prop_gain}) * d;
	assign ki_prod = $signed({1'b0, cfg.pll_integral_gain}) * d;
	assign new_phase = phase_q + rate_q + pg_q[31:0];
	assign new_rate = sat32(64'(rate_q) + 64'(ig_q));

	// quadrant fold so the cell row only sees the right half plane
	always_comb begin
		rot_word.x   = CW'(x0_q);
		rot_word.y   = CW'(y0_q);
		rot_word.ang = 32'd0;
		if (x0_q < 0) begin
			if (y0_q >= 0) begin
				rot_word.x   = CW'(y0_q);
				rot_word.y   = -CW'(x0_q);
				rot_word.ang = QUARTER_TURN;
			end else begin
				rot_word.x   = -CW'(y0_q);
				rot_word.y   = CW'(x0_q);
				rot_word.ang = THREE_QUARTER_TURN;
			end
		end
	end

	assign chain_w[0] = rot_word;
	assign cv[0] = (state_q == ST_ROT);

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cell
		pfo_cordic_cell u_cell (
			.clk(clk), .arst_n(arst_n),
			.shift(5'(i)), .atan_step(ATAN_TURNS[i]),
			.in_valid(cv[i]), .in_word(chain_w[i]),
			.out_valid(cv[i+1]), .out_word(chain_w[i+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			flux_a_q  <= '0;
			flux_b_q  <= '0;
			phase_q   <= '0;
			rate_q    <= '0;
			m_valid_q <= 1'b0;
		end else begin
			if (m_valid_q && m_tready && !(state_q == ST_PLL2 && pll_go))
				m_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: if (s_tvalid) state_q <= ST_LI;
				ST_LI:   state_q <= ST_E;
				ST_E:    state_q <= ST_SQ;
				ST_SQ:   state_q <= ST_ERR;
				ST_ERR:  state_q <= ST_G;
				ST_G:    state_q <= ST_C;
				ST_C:    state_q <= ST_F;
				ST_F: begin
					flux_a_q <= na;
					flux_b_q <= nb;
					state_q  <= ST_ROT;
				end
				ST_ROT:  state_q <= ST_COR;
				ST_COR:  if (cv[CORDIC_STEPS]) state_q <= ST_PLL1;
				ST_PLL1: state_q <= ST_PLL2;
				ST_PLL2: if (pll_go) begin
					phase_q   <= new_phase;
					rate_q    <= new_rate;
					m_valid_q <= 1'b1;
					state_q   <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && s_tvalid) begin
			ia_q <= s_tdata[15:0];
			ib_q <= s_tdata[31:16];
			va_q <= s_tdata[47:32];
			vb_q <= s_tdata[63:48];
		end
		if (state_q == ST_LI) begin
			li_a_q <= la_prod[40:4];
			li_b_q <= lb_prod[40:4];
			ri_a_q <= $signed({1'b0, cfg.resistance}) * ia_q;
			ri_b_q <= $signed({1'b0, cfg.resistance}) * ib_q;
			psi2_q <= cfg.flux_linkage * cfg.flux_linkage;
		end
		if (state_q == ST_E) begin
			sa_q      <= sat_ea[31:6];
			sb_q      <= sat_eb[31:6];
			e20_a_q   <= sat_ea[31:10];
			e20_b_q   <= sat_eb[31:10];
			drv22_a_q <= 34'($signed({va_q, 14'd0})) - 34'(ri_a_q);
			drv22_b_q <= 34'($signed({vb_q, 14'd0})) - 34'(ri_b_q);
		end
		if (state_q == ST_SQ) begin
			sqa_q   <= sa_q * sa_q;
			sqb_q   <= sb_q * sb_q;
			drv_a_q <= drv22_a_q * $signed({1'b0, cfg.step_seconds});
			drv_b_q <= drv22_b_q * $signed({1'b0, cfg.step_seconds});
		end
		if (state_q == ST_ERR) begin
			// magnitude error clamps at zero from above
			err32_q  <= (err_full > 0) ? 38'sd0 : err_full[53:16];
			dr30_a_q <= drv_a_q[58:24];
			dr30_b_q <= drv_b_q[58:24];
		end
		if (state_q == ST_G)
			g20_q <= g_prod[62:24];
		if (state_q == ST_C) begin
			corr_a_q <= ca_prod[60:10];
			corr_b_q <= cb_prod[60:10];
		end
		if (state_q == ST_F) begin
			x0_q <= 38'(na) - 38'(li_a_q);
			y0_q <= 38'(nb) - 38'(li_b_q);
		end
		if (state_q == ST_ROT)
			zero_q <= (x0_q == 0) && (y0_q == 0);
		if (state_q == ST_COR && cv[CORDIC_STEPS])
			seen_q <= zero_q ? 32'd0 : chain_w[CORDIC_STEPS].ang;
		if (state_q == ST_PLL1) begin
			pg_q <= kp_prod[48:16];
			ig_q <= ki_prod[56:32];
		end
		if (state_q == ST_PLL2 && pll_go)
			m_data_q <= {new_rate, new_phase[31:16], seen_q[31:16]};
	end

	a_one_token: assert property (@(posedge clk) disable iff (!arst_n) $onehot0(cv))
		else $error("more than one vector in the CORDIC row");
	a_idle_row: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |-> (cv == '0))
		else $error("word accepted while CORDIC row busy");
	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(state_q == ST_PLL2))
		else $error("result raised outside loop update");

endmodule
